// File: src/ilir_pkg.sv
// Shared constants, types and stream field layout for the indexed list core.
`default_nettype none
package ilir_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Input request fields.
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 10;
	localparam int END_W   = 9;
	localparam int VALUE_W = 64;
	localparam int CMD_LSB = 0;
	localparam int IDX_LSB = CMD_LSB + CMD_W;
	localparam int END_LSB = IDX_LSB + IDX_W;
	localparam int VAL_LSB = END_LSB + END_W;
	localparam int IN_BITS = VAL_LSB + VALUE_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// Result fields.
	localparam int RD_W     = 64;
	localparam int LEN_W    = 9;
	localparam int ST_W     = 2;
	localparam int RD_LSB   = 0;
	localparam int LEN_LSB  = RD_LSB + RD_W;
	localparam int ST_LSB   = LEN_LSB + LEN_W;
	localparam int OUT_BITS = ST_LSB + ST_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Width for resolving a signed position against the length.
	localparam int RES_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ      = 3'd0,
		CMD_WRITE     = 3'd1,
		CMD_APPEND    = 3'd2,
		CMD_INSERT    = 3'd3,
		CMD_REM_LAST  = 3'd4,
		CMD_REM_AT    = 3'd5,
		CMD_REM_RANGE = 3'd6
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

endpackage
`default_nettype wire

// File: src/ilir_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module ilir_ram #(
	parameter int DEPTH_P = 256,
	parameter int WIDTH_P = 64,
	parameter int AW_P    = $clog2(DEPTH_P)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW_P-1:0]    waddr,
	input  wire logic [WIDTH_P-1:0] wdata,
	input  wire logic               re,
	input  wire logic [AW_P-1:0]    raddr,
	output logic      [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/ilir_ctrl.sv
// Command sequencer: decodes requests, walks shifts through the RAM and holds the result.
`default_nettype none
module ilir_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_valid,
	output logic                                  s_ready,
	input  wire logic [ilir_pkg::IN_TDATA_W-1:0]  s_data,
	output logic                                  m_valid,
	input  wire logic                             m_ready,
	output logic      [ilir_pkg::OUT_TDATA_W-1:0] m_data,
	output ilir_pkg::mem_req_t                    mem_req,
	input  wire logic [ilir_pkg::DATA_WIDTH-1:0]  mem_rdata
);
	import ilir_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_RDDAT,
		S_PUT,
		S_SHIFT,
		S_DRAIN,
		S_DONE
	} state_t;

	localparam logic signed [RES_W-1:0] ONE_X = RES_W'(1);

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [ADDR_W-1:0]      ptr_q;
	logic [ADDR_W-1:0]      stop_q;
	logic [ADDR_W-1:0]      dist_q;
	logic                   up_q;
	logic                   put_after_q;
	logic [DATA_WIDTH-1:0]  val_q;
	logic [RD_W-1:0]        res_rd_q;
	status_t                res_st_q;
	logic                   wvld_s1;
	logic [ADDR_W-1:0]      waddr_s1;
	logic                   m_valid_q;
	logic [RD_W-1:0]        out_rd_q;
	logic [LEN_W-1:0]       out_len_q;
	status_t                out_st_q;

	cmd_t                   cmd;
	logic [IDX_W-1:0]       idx_raw;
	logic [END_W-1:0]       end_raw;
	logic signed [RES_W-1:0] cnt_x, p_x, q_x, p_res, q_res, p_nxt, q_nxt, span_x;
	logic                   p_in, q_in, p_ins, full, empty, accept;

	assign accept = s_valid && s_ready;
	assign s_ready = (state_q == S_IDLE);

	// Resolve the signed positions against the current length.
	always_comb begin
		cmd     = cmd_t'(s_data[CMD_LSB +: CMD_W]);
		idx_raw = s_data[IDX_LSB +: IDX_W];
		end_raw = s_data[END_LSB +: END_W];
		cnt_x   = signed'({{(RES_W-CNT_W){1'b0}}, cnt_q});
		p_x     = signed'({{(RES_W-IDX_W){idx_raw[IDX_W-1]}}, idx_raw});
		q_x     = signed'({{(RES_W-END_W){end_raw[END_W-1]}}, end_raw});
		p_res   = idx_raw[IDX_W-1] ? cnt_x + p_x : p_x;
		q_res   = end_raw[END_W-1] ? cnt_x + q_x : q_x;
		p_in    = !p_res[RES_W-1] && (p_res < cnt_x);
		q_in    = !q_res[RES_W-1] && (q_res < cnt_x);
		p_ins   = !p_res[RES_W-1] && (p_res <= cnt_x);
		p_nxt   = p_res + ONE_X;
		q_nxt   = q_res + ONE_X;
		span_x  = q_res - p_res + ONE_X;
		full    = (cnt_q == CNT_W'(DEPTH));
		empty   = (cnt_q == '0);
	end

	// RAM port: shift write-back takes priority; otherwise a single put.
	always_comb begin
		mem_req = '0;
		if (wvld_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = waddr_s1;
			mem_req.wdata = mem_rdata;
		end else if (state_q == S_PUT) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = addr_q;
			mem_req.wdata = val_q;
		end
		if (state_q == S_SHIFT) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = ptr_q;
		end else if (state_q == S_RD) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			wvld_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			wvld_s1 <= (state_q == S_SHIFT);
			if (m_valid_q && m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q       <= s_data[VAL_LSB +: DATA_WIDTH];
						res_rd_q    <= '0;
						res_st_q    <= ST_OK;
						put_after_q <= 1'b0;
						addr_q      <= p_res[ADDR_W-1:0];
						state_q     <= S_DONE;
						case (cmd)
							CMD_READ: begin
								if (p_in) begin
									state_q <= S_RD;
								end else begin
									res_st_q <= ST_RANGE;
								end
							end
							CMD_WRITE: begin
								if (p_in) begin
									state_q <= S_PUT;
								end else begin
									res_st_q <= ST_RANGE;
								end
							end
							CMD_APPEND: begin
								if (full) begin
									res_st_q <= ST_FULL;
								end else begin
									addr_q  <= cnt_q[ADDR_W-1:0];
									cnt_q   <= cnt_q + 1'b1;
									state_q <= S_PUT;
								end
							end
							CMD_INSERT: begin
								if (full) begin
									res_st_q <= ST_FULL;
								end else if (!p_ins) begin
									res_st_q <= ST_RANGE;
								end else begin
									cnt_q <= cnt_q + 1'b1;
									if (p_res == cnt_x) begin
										state_q <= S_PUT;
									end else begin
										// Move entries up, last first, then drop the word in.
										ptr_q       <= ADDR_W'(cnt_q - 1'b1);
										stop_q      <= p_res[ADDR_W-1:0];
										up_q        <= 1'b0;
										dist_q      <= ADDR_W'(1);
										put_after_q <= 1'b1;
										state_q     <= S_SHIFT;
									end
								end
							end
							CMD_REM_LAST: begin
								if (empty) begin
									res_st_q <= ST_EMPTY;
								end else begin
									cnt_q <= cnt_q - 1'b1;
								end
							end
							CMD_REM_AT: begin
								if (empty) begin
									res_st_q <= ST_EMPTY;
								end else if (!p_in) begin
									res_st_q <= ST_RANGE;
								end else begin
									cnt_q <= cnt_q - 1'b1;
									if (p_nxt < cnt_x) begin
										ptr_q   <= p_nxt[ADDR_W-1:0];
										stop_q  <= ADDR_W'(cnt_q - 1'b1);
										up_q    <= 1'b1;
										dist_q  <= ADDR_W'(1);
										state_q <= S_SHIFT;
									end
								end
							end
							CMD_REM_RANGE: begin
								if (empty) begin
									res_st_q <= ST_EMPTY;
								end else if (!p_in || !q_in) begin
									res_st_q <= ST_RANGE;
								end else if (p_res <= q_res) begin
									cnt_q <= cnt_q - span_x[CNT_W-1:0];
									if (q_nxt < cnt_x) begin
										ptr_q   <= q_nxt[ADDR_W-1:0];
										stop_q  <= ADDR_W'(cnt_q - 1'b1);
										up_q    <= 1'b1;
										dist_q  <= span_x[ADDR_W-1:0];
										state_q <= S_SHIFT;
									end
								end
							end
							default: begin
								res_st_q <= ST_OK;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_RDDAT;
				end
				S_RDDAT: begin
					res_rd_q <= RD_W'(mem_rdata);
					state_q  <= S_DONE;
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					waddr_s1 <= up_q ? ptr_q - dist_q : ptr_q + dist_q;
					if (ptr_q == stop_q) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= up_q ? ptr_q + 1'b1 : ptr_q - 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= put_after_q ? S_PUT : S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_ready) begin
						m_valid_q <= 1'b1;
						out_rd_q  <= res_rd_q;
						out_len_q <= LEN_W'(cnt_q);
						out_st_q  <= res_st_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_st_q, out_len_q, out_rd_q};

endmodule
`default_nettype wire

// File: src/indexed_list_insert_remove_core.sv
// Top level of the indexed list core: sequencer plus element RAM.
// Commands that only touch the length or fail go straight to the result stage; write and
// append add a RAM write, read adds a RAM read, and remove and insert walk the moved
// entries with one RAM read and write per cycle (insert then writes the new word).
// One request at a time, taken once the last result is in the output register.
// arst_n clears the length to zero; RAM contents are left as they are.
`default_nettype none
module indexed_list_insert_remove_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// command, index, range_end, value, zero pad
	input  wire logic [ilir_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// read_data, list_length, status, zero pad
	output logic      [ilir_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ilir_pkg::*;

	mem_req_t              mem_req;
	logic [DATA_WIDTH-1:0] mem_rdata;

	ilir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_data    (s_axis_tdata),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	ilir_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_WIDTH),
		.AW_P    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

// File: src/ilir_checker.sv
// Port-level assertions for the indexed list core, bound to the top level.
`default_nettype none
module ilir_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [ilir_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ilir_pkg::*;

	logic [RD_W-1:0]  rd;
	logic [LEN_W-1:0] len;
	logic [ST_W-1:0]  st;

	assign rd  = m_axis_tdata[RD_LSB +: RD_W];
	assign len = m_axis_tdata[LEN_LSB +: LEN_W];
	assign st  = m_axis_tdata[ST_LSB +: ST_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> len <= LEN_W'(DEPTH))
		else $error("length above capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != ST_OK |-> rd == '0)
		else $error("read data not zero on a failed request");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == ST_FULL |-> len == LEN_W'(DEPTH))
		else $error("full status with room left");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == ST_EMPTY |-> len == '0)
		else $error("empty status with entries held");

endmodule

bind indexed_list_insert_remove_core ilir_checker u_ilir_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
